// ===== src/limit_order_book_matcher_macros.svh =====
// Assertion macros for the limit order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LOB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lob check failed");
`define LOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lob check failed");
`endif

// ===== src/lob_pkg.sv =====
// Shared types and constants for the limit order book matcher
`default_nettype none
package lob_pkg;
  localparam int unsigned SIDE_DEPTH_DEF = 32;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned QTY_W = 16;
  localparam int unsigned ID_W = 32;

  typedef enum logic [1:0] {
    REQ_BUY    = 2'd0,
    REQ_SELL   = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_TRADE     = 3'd0,
    ST_RESTED    = 3'd1,
    ST_FILLED    = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_DROPPED   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MATCH,
    S_TRADE_OUT,
    S_REST,
    S_CSCAN,
    S_FINAL_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== src/limit_order_book_matcher.sv =====
// Price-time priority limit order book matcher, top level
// One request at a time. A place request scans the opposite side one slot per
// cycle to find the best order, then applies the fill in S_MATCH and presents
// the trade beat in S_TRADE_OUT; this repeats per fill. Resting the remainder
// scans the own side for the lowest free slot, a cancel scans bids then asks.
// The final status beat follows. The scans step slot by slot through a single
// comparator over the slot registers.
`default_nettype none
`include "limit_order_book_matcher_macros.svh"
module limit_order_book_matcher #(
  parameter int unsigned SIDE_DEPTH = lob_pkg::SIDE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [19:0] in_limit_price,
  input  wire logic [15:0] in_order_qty,
  input  wire logic [31:0] in_cancel_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_taker_id,
  output logic [31:0]      out_maker_id,
  output logic [19:0]      out_trade_price,
  output logic [15:0]      out_trade_qty,
  output logic [15:0]      out_remaining_qty,
  output logic             out_book_empty,
  output logic             out_last
);
  import lob_pkg::*;

  localparam int unsigned IDX_W = $clog2(SIDE_DEPTH);
  localparam int unsigned CNT_W = $clog2(SIDE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SIDE_DEPTH - 1);

  logic [SIDE_DEPTH-1:0] bid_valid_r, ask_valid_r;
  logic [ID_W-1:0]    bid_id_r [SIDE_DEPTH];
  logic [PRICE_W-1:0] bid_pr_r [SIDE_DEPTH];
  logic [QTY_W-1:0]   bid_q_r  [SIDE_DEPTH];
  logic [ID_W-1:0]    ask_id_r [SIDE_DEPTH];
  logic [PRICE_W-1:0] ask_pr_r [SIDE_DEPTH];
  logic [QTY_W-1:0]   ask_q_r  [SIDE_DEPTH];

  state_t state_r, state_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;
  logic is_buy_r, is_buy_nxt;
  logic [PRICE_W-1:0] limit_r, limit_nxt;
  logic [QTY_W-1:0] qty_r, qty_nxt;
  logic [ID_W-1:0] taker_r, taker_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [PRICE_W-1:0] best_pr_r, best_pr_nxt;
  logic [ID_W-1:0] best_id_r, best_id_nxt;
  logic cside_r, cside_nxt;

  logic [2:0] o_status_r, o_status_nxt;
  logic [ID_W-1:0] o_maker_r, o_maker_nxt;
  logic [PRICE_W-1:0] o_price_r, o_price_nxt;
  logic [QTY_W-1:0] o_tqty_r, o_tqty_nxt;
  logic [QTY_W-1:0] o_rem_r, o_rem_nxt;
  logic o_last_r, o_last_nxt;

  // one-slot shared read port and write request
  logic [IDX_W-1:0] ix;
  logic sv, ov;
  logic [ID_W-1:0] o_id;
  logic [PRICE_W-1:0] o_pr;
  logic [QTY_W-1:0] o_q;
  logic [ID_W-1:0] c_id;
  logic better;
  logic [QTY_W-1:0] t_q, bq;
  logic wr_q, clr_v, set_v, wr_side_bid;
  logic [QTY_W-1:0] wr_qv;
  logic [IDX_W-1:0] wr_ix;
  logic fire_out;

  assign ix = idx_r[IDX_W-1:0];
  always_comb begin
    sv   = is_buy_r ? bid_valid_r[ix] : ask_valid_r[ix];
    ov   = is_buy_r ? ask_valid_r[ix] : bid_valid_r[ix];
    o_id = is_buy_r ? ask_id_r[ix] : bid_id_r[ix];
    o_pr = is_buy_r ? ask_pr_r[ix] : bid_pr_r[ix];
    c_id = cside_r ? ask_id_r[ix] : bid_id_r[ix];
    bq   = is_buy_r ? ask_q_r[best_r] : bid_q_r[best_r];
    o_q  = bq;
    if (o_pr == best_pr_r) better = o_id < best_id_r;
    else if (is_buy_r) better = o_pr < best_pr_r;
    else better = o_pr > best_pr_r;
    t_q = (qty_r < o_q) ? qty_r : o_q;
  end

  assign fire_out = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    next_id_nxt = next_id_r;
    is_buy_nxt = is_buy_r;
    limit_nxt = limit_r;
    qty_nxt = qty_r;
    taker_nxt = taker_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    best_nxt = best_r;
    best_pr_nxt = best_pr_r;
    best_id_nxt = best_id_r;
    cside_nxt = cside_r;
    o_status_nxt = o_status_r;
    o_maker_nxt = o_maker_r;
    o_price_nxt = o_price_r;
    o_tqty_nxt = o_tqty_r;
    o_rem_nxt = o_rem_r;
    o_last_nxt = o_last_r;
    wr_q = 1'b0;
    clr_v = 1'b0;
    set_v = 1'b0;
    wr_side_bid = 1'b0;
    wr_qv = '0;
    wr_ix = ix;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          limit_nxt = in_limit_price;
          qty_nxt = in_order_qty;
          is_buy_nxt = (in_req_type == REQ_BUY);
          idx_nxt = '0;
          found_nxt = 1'b0;
          o_maker_nxt = '0;
          o_price_nxt = '0;
          o_tqty_nxt = '0;
          o_rem_nxt = '0;
          o_last_nxt = 1'b1;
          if (in_req_type == REQ_BUY || in_req_type == REQ_SELL) begin
            next_id_nxt = next_id_r + 1'b1;
            taker_nxt = next_id_r + 1'b1;
            state_nxt = S_SCAN;
          end else if (in_req_type == REQ_CANCEL) begin
            taker_nxt = in_cancel_id;
            cside_nxt = 1'b0;
            state_nxt = S_CSCAN;
          end
        end
      end
      S_SCAN: begin
        if (qty_r == '0) begin
          o_status_nxt = ST_FILLED;
          o_rem_nxt = '0;
          o_last_nxt = 1'b1;
          state_nxt = S_FINAL_OUT;
        end else if (idx_r == CNT_W'(SIDE_DEPTH)) begin
          idx_nxt = '0;
          if (found_r && (is_buy_r ? (best_pr_r <= limit_r) : (best_pr_r >= limit_r)))
            state_nxt = S_MATCH;
          else
            state_nxt = S_REST;
        end else begin
          if (ov && (!found_r || better)) begin
            found_nxt = 1'b1;
            best_nxt = ix;
            best_pr_nxt = o_pr;
            best_id_nxt = o_id;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MATCH: begin
        qty_nxt = qty_r - t_q;
        wr_q = 1'b1;
        wr_ix = best_r;
        wr_side_bid = !is_buy_r;
        wr_qv = o_q - t_q;
        clr_v = (o_q == t_q);
        o_status_nxt = ST_TRADE;
        o_maker_nxt = best_id_r;
        o_price_nxt = best_pr_r;
        o_tqty_nxt = t_q;
        o_rem_nxt = qty_r - t_q;
        o_last_nxt = 1'b0;
        state_nxt = S_TRADE_OUT;
      end
      S_TRADE_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = '0;
          found_nxt = 1'b0;
          o_maker_nxt = '0;
          o_price_nxt = '0;
          o_tqty_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_REST: begin
        o_last_nxt = 1'b1;
        o_rem_nxt = qty_r;
        if (!sv) begin
          set_v = 1'b1;
          wr_side_bid = is_buy_r;
          o_status_nxt = ST_RESTED;
          state_nxt = S_FINAL_OUT;
        end else if (idx_r == LAST_IDX) begin
          o_status_nxt = ST_DROPPED;
          state_nxt = S_FINAL_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CSCAN: begin
        if ((cside_r ? ask_valid_r[ix] : bid_valid_r[ix]) && c_id == taker_r) begin
          clr_v = 1'b1;
          wr_side_bid = !cside_r;
          o_status_nxt = ST_CANCELLED;
          state_nxt = S_FINAL_OUT;
        end else if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
          if (cside_r) begin
            o_status_nxt = ST_NOT_FOUND;
            state_nxt = S_FINAL_OUT;
          end else begin
            cside_nxt = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FINAL_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      next_id_r <= '0;
      bid_valid_r <= '0;
      ask_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      next_id_r <= next_id_nxt;
      if (clr_v) begin
        if (wr_side_bid) bid_valid_r[wr_ix] <= 1'b0;
        else ask_valid_r[wr_ix] <= 1'b0;
      end
      if (set_v) begin
        if (wr_side_bid) bid_valid_r[wr_ix] <= 1'b1;
        else ask_valid_r[wr_ix] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_buy_r <= is_buy_nxt;
    limit_r <= limit_nxt;
    qty_r <= qty_nxt;
    taker_r <= taker_nxt;
    idx_r <= idx_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    best_pr_r <= best_pr_nxt;
    best_id_r <= best_id_nxt;
    cside_r <= cside_nxt;
    o_status_r <= o_status_nxt;
    o_maker_r <= o_maker_nxt;
    o_price_r <= o_price_nxt;
    o_tqty_r <= o_tqty_nxt;
    o_rem_r <= o_rem_nxt;
    o_last_r <= o_last_nxt;
    if (wr_q) begin
      if (wr_side_bid) bid_q_r[wr_ix] <= wr_qv;
      else ask_q_r[wr_ix] <= wr_qv;
    end
    if (set_v) begin
      if (wr_side_bid) begin
        bid_id_r[wr_ix] <= taker_r;
        bid_pr_r[wr_ix] <= limit_r;
        bid_q_r[wr_ix] <= qty_r;
      end else begin
        ask_id_r[wr_ix] <= taker_r;
        ask_pr_r[wr_ix] <= limit_r;
        ask_q_r[wr_ix] <= qty_r;
      end
    end
  end

  assign out_status = o_status_r;
  assign out_taker_id = taker_r;
  assign out_maker_id = o_maker_r;
  assign out_trade_price = o_price_r;
  assign out_trade_qty = o_tqty_r;
  assign out_remaining_qty = o_rem_r;
  assign out_book_empty = (bid_valid_r == '0) && (ask_valid_r == '0);
  assign out_last = o_last_r;

  `LOB_ASSERT_IMPL(a_busy_not_ready, state_r != S_IDLE, !in_ready)
  `LOB_ASSERT_IMPL(a_trade_not_last, out_valid && o_status_r == ST_TRADE, !o_last_r)
  `LOB_ASSERT_NEXT(a_final_to_idle, state_r == S_FINAL_OUT && fire_out, state_r == S_IDLE)
  `LOB_ASSERT_IMPL(a_trade_qty_nz, out_valid && o_status_r == ST_TRADE, o_tqty_r != '0)
endmodule
`default_nettype wire
